/* hdl/nnps_pkg.sv */
// Shared types and constants of the nearest neighbor pixel scaler.
package nnps_pkg;

    // Field widths fixed by the stream format
    localparam int PIXEL_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int ACC_W      = 16;
    localparam int SWIDTH_W   = 11;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP   = 2'd0,
        CFG_UNIT   = 2'd1,
        CFG_WIDTH  = 2'd2,
        CFG_HEIGHT = 2'd3
    } t_cfg_idx;

    // Input item kinds carried on tuser
    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_REPLAY = 1'b1;

    // Register values after reset
    localparam logic [ACC_W-1:0]    RST_STEP   = 16'd100;
    localparam logic [ACC_W-1:0]    RST_UNIT   = 16'd100;
    localparam logic [SWIDTH_W-1:0] RST_WIDTH  = 11'd1024;
    localparam logic [ACC_W-1:0]    RST_HEIGHT = 16'd1024;

    // Current configuration as seen by the front end
    typedef struct packed {
        logic [ACC_W-1:0]    step;
        logic [ACC_W-1:0]    unit;
        logic [SWIDTH_W-1:0] width;
        logic [ACC_W-1:0]    height;
    } t_cfg;

endpackage

/* hdl/nearest_neighbor_pixel_scaler_core.sv */
// Top level of the nearest neighbor pixel scaler: configuration registers and datapath.
//
//  Channel   Direction  Handshake                     Payload
//  cfg       in         i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//  s_axis    in         s_axis_tvalid / tready        tdata pixel, tuser kind
//  m_axis    out        m_axis_tvalid / tready        tdata pixel, tlast run end, tuser row end
//
// The front end takes one item per cycle unless busy or the queue is full; the copy engine
// sends one pixel copy per cycle while the output is ready, with a four-entry queue between.
// A write to the unit register renormalizes both accumulators, during which neither items
// nor configuration writes are taken. Reset is synchronous, active low; the line buffer
// needs no clearing pass. Either side may stall without losing items.
module nearest_neighbor_pixel_scaler_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_REPEAT = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [nnps_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [nnps_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [nnps_pkg::PIXEL_W-1:0]        s_axis_tdata,  // [31:0] pixel
    input  logic                                s_axis_tuser,  // [0] kind
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [nnps_pkg::PIXEL_W-1:0]        m_axis_tdata,  // [31:0] out_pixel
    output logic                                m_axis_tlast,
    output logic                                m_axis_tuser   // [0] row_end
);

    import nnps_pkg::*;

    localparam int QB    = $clog2(MAX_REPEAT + 1);
    localparam int ENT_W = PIXEL_W + QB + 1;

    t_cfg              r_cfg;
    logic              cfg_wr;
    logic              unit_wr;
    logic              busy;
    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_empty;
    logic [ENT_W-1:0]  q_in;
    logic [ENT_W-1:0]  q_out;

    assign o_cfg_ready = !busy;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign unit_wr     = cfg_wr && (t_cfg_idx'(i_cfg_index) == CFG_UNIT);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step   <= RST_STEP;
            r_cfg.unit   <= RST_UNIT;
            r_cfg.width  <= RST_WIDTH;
            r_cfg.height <= RST_HEIGHT;
        end else if (cfg_wr) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_STEP:   r_cfg.step   <= i_cfg_data;
                CFG_UNIT:   r_cfg.unit   <= i_cfg_data;
                CFG_WIDTH:  r_cfg.width  <= i_cfg_data[SWIDTH_W-1:0];
                CFG_HEIGHT: r_cfg.height <= i_cfg_data;
                default:    r_cfg        <= r_cfg;
            endcase
        end
    end

    nnps_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_REPEAT (MAX_REPEAT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_unit_wr (unit_wr),
        .o_busy    (busy),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_kind    (s_axis_tuser),
        .i_pixel   (s_axis_tdata),
        .o_push    (q_push),
        .o_entry   (q_in),
        .i_full    (q_full)
    );

    nnps_fifo #(
        .WIDTH (ENT_W),
        .DEPTH (4)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    nnps_back #(
        .MAX_REPEAT (MAX_REPEAT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (q_empty),
        .i_entry   (q_out),
        .o_pop     (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_pixel   (m_axis_tdata),
        .o_last    (m_axis_tlast),
        .o_row_end (m_axis_tuser)
    );

endmodule

/* hdl/nnps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module nnps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port, and read port that holds its data until the next read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/nnps_fifo.sv */
// Short command queue between the front end and the copy engine.
module nnps_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= PW'(r_wr_ptr + 1'b1);
            end
            if (do_pop) begin
                r_rd_ptr <= PW'(r_rd_ptr + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_count <= CW'(r_count + 1'b1);
            end else if (do_pop && !do_push) begin
                r_count <= CW'(r_count - 1'b1);
            end
        end
    end

endmodule

/* hdl/nnps_front.sv */
// Front end: accepts items, runs the rate accumulators and the line buffer, issues copy commands.
module nnps_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_REPEAT = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  nnps_pkg::t_cfg           i_cfg,
    input  logic                     i_unit_wr,
    output logic                     o_busy,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_kind,
    input  logic [nnps_pkg::PIXEL_W-1:0] i_pixel,
    output logic                     o_push,
    output logic [nnps_pkg::PIXEL_W+$clog2(MAX_REPEAT+1):0] o_entry,
    input  logic                     i_full
);

    import nnps_pkg::*;

    localparam int CB  = $clog2(MAX_WIDTH);
    localparam int WB  = $clog2(MAX_WIDTH + 1);
    localparam int QB  = $clog2(MAX_REPEAT + 1);
    localparam int SW  = ACC_W + QB;
    localparam int NCW = $clog2(ACC_W);
    localparam int LW  = PIXEL_W + QB;

    typedef enum logic {ST_RUN, ST_NORM} t_state;

    // Add the clamped step, take out whole units, return remainder and count
    function automatic logic [ACC_W+QB-1:0] f_advance(
        input logic [ACC_W-1:0] rem,
        input logic [QB-1:0]    exc,
        input logic [SW-1:0]    s_in,
        input logic [ACC_W-1:0] u_in
    );
        logic [SW-1:0] sum;
        logic [QB-1:0] q;
        logic [QB:0]   tot;
        logic [QB-1:0] cnt;
        sum = SW'(rem) + s_in;
        q   = '0;
        for (int i = QB - 1; i >= 0; i--) begin
            if (sum >= (SW'(u_in) << i)) begin
                sum  = sum - (SW'(u_in) << i);
                q[i] = 1'b1;
            end
        end
        tot = (QB+1)'(exc) + (QB+1)'(q);
        cnt = (tot > (QB+1)'(MAX_REPEAT)) ? QB'(MAX_REPEAT) : tot[QB-1:0];
        return {sum[ACC_W-1:0], cnt};
    endfunction

    // Architectural state
    t_state          r_state,         n_state;
    logic [CB-1:0]   r_column,        n_column;
    logic [ACC_W-1:0] r_row_index,    n_row_index;
    logic [QB-1:0]   r_row_copies,    n_row_copies;
    logic [QB-1:0]   r_replays_left,  n_replays_left;
    logic [CB-1:0]   r_replay_column, n_replay_column;
    logic [ACC_W-1:0] r_h_acc,        n_h_acc;
    logic [ACC_W-1:0] r_h_rem,        n_h_rem;
    logic [QB-1:0]   r_h_exc,         n_h_exc;
    logic [ACC_W-1:0] r_v_acc,        n_v_acc;
    logic [ACC_W-1:0] r_v_rem,        n_v_rem;
    logic [QB-1:0]   r_v_exc,         n_v_exc;
    // Accumulator renormalization after a unit change
    logic [NCW-1:0]  r_norm_cnt,      n_norm_cnt;
    logic [ACC_W-1:0] r_nh_part,      n_nh_part;
    logic [ACC_W-1:0] r_nh_q,         n_nh_q;
    logic [ACC_W-1:0] r_nv_part,      n_nv_part;
    logic [ACC_W-1:0] r_nv_q,         n_nv_q;
    // Command stage
    logic            r_f1_valid,      n_f1_valid;
    logic            r_f1_replay,     n_f1_replay;
    logic [PIXEL_W-1:0] r_f1_pixel,   n_f1_pixel;
    logic [QB-1:0]   r_f1_count,      n_f1_count;
    logic            r_f1_row_end,    n_f1_row_end;

    logic [ACC_W-1:0] u;
    logic [SW-1:0]   lim;
    logic [SW-1:0]   s;
    logic [WB-1:0]   w;
    logic [ACC_W-1:0] hgt;
    logic            accept;
    logic            pix_go;
    logic            rep_go;
    logic [CB-1:0]   col0;
    logic [CB-1:0]   rcol0;
    logic            row_start;
    logic            pix_last;
    logic            rep_last;
    logic [ACC_W-1:0] v_rem_n;
    logic [QB-1:0]   v_cnt;
    logic [ACC_W-1:0] h_rem_n;
    logic [QB-1:0]   h_cnt;
    logic [QB-1:0]   copies;
    logic [ACC_W-1:0] row_nx;
    logic [NCW-1:0]  bit_idx;
    logic [ACC_W:0]  nh_t;
    logic [ACC_W:0]  nv_t;
    logic            nh_ge;
    logic            nv_ge;
    logic [ACC_W-1:0] nh_part_step;
    logic [ACC_W-1:0] nv_part_step;
    logic [ACC_W-1:0] nh_q_step;
    logic [ACC_W-1:0] nv_q_step;
    logic [LW-1:0]   ram_rdata;
    logic [QB-1:0]   ent_cnt;
    logic [PIXEL_W-1:0] ent_pixel;

    // Effective configuration
    assign u   = (i_cfg.unit == '0) ? ACC_W'(1) : i_cfg.unit;
    assign lim = SW'(u) * SW'(MAX_REPEAT);
    assign s   = (SW'(i_cfg.step) < lim) ? SW'(i_cfg.step) : lim;
    assign hgt = (i_cfg.height == '0) ? ACC_W'(1) : i_cfg.height;

    always_comb begin
        if (i_cfg.width == '0) begin
            w = WB'(1);
        end else if (32'(i_cfg.width) > 32'(MAX_WIDTH)) begin
            w = WB'(MAX_WIDTH);
        end else begin
            w = WB'(i_cfg.width);
        end
    end

    // Classify the item
    assign o_busy  = (r_state == ST_NORM);
    assign o_ready = (r_state == ST_RUN) && (!r_f1_valid || !i_full);
    assign accept  = i_valid && o_ready;
    assign pix_go  = accept && (i_kind == KIND_PIXEL) && (r_replays_left == '0);
    assign rep_go  = accept && (i_kind == KIND_REPLAY) && (r_replays_left != '0);

    // Column positions, wrapped when the width has shrunk
    assign col0      = (WB'(r_column) >= w) ? '0 : r_column;
    assign rcol0     = (WB'(r_replay_column) >= w) ? '0 : r_replay_column;
    assign row_start = (col0 == '0);
    assign pix_last  = ((WB'(col0) + WB'(1)) >= w);
    assign rep_last  = ((WB'(rcol0) + WB'(1)) >= w);

    // Vertical and horizontal rate accumulators
    assign {v_rem_n, v_cnt} = f_advance(r_v_rem, r_v_exc, s, u);
    assign {h_rem_n, h_cnt} = f_advance(row_start ? '0 : r_h_rem,
                                        row_start ? '0 : r_h_exc, s, u);
    assign copies = row_start ? v_cnt : r_row_copies;
    assign row_nx = r_row_index + ACC_W'(1);

    // One long-division step on each stored accumulator
    assign bit_idx      = NCW'(ACC_W - 1) - r_norm_cnt;
    assign nh_t         = {r_nh_part, r_h_acc[bit_idx]};
    assign nv_t         = {r_nv_part, r_v_acc[bit_idx]};
    assign nh_ge        = (nh_t >= (ACC_W+1)'(u));
    assign nv_ge        = (nv_t >= (ACC_W+1)'(u));
    assign nh_part_step = nh_ge ? ACC_W'(nh_t - (ACC_W+1)'(u)) : nh_t[ACC_W-1:0];
    assign nv_part_step = nv_ge ? ACC_W'(nv_t - (ACC_W+1)'(u)) : nv_t[ACC_W-1:0];
    assign nh_q_step    = {r_nh_q[ACC_W-2:0], nh_ge};
    assign nv_q_step    = {r_nv_q[ACC_W-2:0], nv_ge};

    // Line buffer: pixel and its copy count per column
    nnps_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (pix_go),
        .i_waddr (col0),
        .i_wdata ({h_cnt, i_pixel}),
        .i_re    (rep_go),
        .i_raddr (rcol0),
        .o_rdata (ram_rdata)
    );

    // Hand the command to the queue; replays take their data from the line buffer
    assign ent_cnt   = r_f1_replay ? ram_rdata[PIXEL_W +: QB] : r_f1_count;
    assign ent_pixel = r_f1_replay ? ram_rdata[PIXEL_W-1:0] : r_f1_pixel;
    assign o_push    = r_f1_valid && !i_full && (ent_cnt != '0);
    assign o_entry   = {r_f1_row_end, ent_cnt, ent_pixel};

    // Next state
    always_comb begin
        n_state         = r_state;
        n_column        = r_column;
        n_row_index     = r_row_index;
        n_row_copies    = r_row_copies;
        n_replays_left  = r_replays_left;
        n_replay_column = r_replay_column;
        n_h_acc         = r_h_acc;
        n_h_rem         = r_h_rem;
        n_h_exc         = r_h_exc;
        n_v_acc         = r_v_acc;
        n_v_rem         = r_v_rem;
        n_v_exc         = r_v_exc;
        n_norm_cnt      = r_norm_cnt;
        n_nh_part       = r_nh_part;
        n_nh_q          = r_nh_q;
        n_nv_part       = r_nv_part;
        n_nv_q          = r_nv_q;
        n_f1_valid      = r_f1_valid;
        n_f1_replay     = r_f1_replay;
        n_f1_pixel      = r_f1_pixel;
        n_f1_count      = r_f1_count;
        n_f1_row_end    = r_f1_row_end;

        // Source pixel: advance accumulators, step the column, close the row
        if (pix_go) begin
            n_row_copies = copies;
            if (row_start) begin
                n_v_acc = v_rem_n;
                n_v_rem = v_rem_n;
                n_v_exc = '0;
            end
            n_h_acc = h_rem_n;
            n_h_rem = h_rem_n;
            n_h_exc = '0;
            if (pix_last) begin
                n_column = '0;
                if (copies > QB'(1)) begin
                    n_replays_left  = QB'(copies - 1'b1);
                    n_replay_column = '0;
                end
                if (row_nx >= hgt) begin
                    n_row_index = '0;
                    n_v_acc     = '0;
                    n_v_rem     = '0;
                    n_v_exc     = '0;
                end else begin
                    n_row_index = row_nx;
                end
            end else begin
                n_column = CB'(col0 + 1'b1);
            end
        end

        // Replay: step the stored column, count down the pending rows
        if (rep_go) begin
            if (rep_last) begin
                n_replay_column = '0;
                n_replays_left  = QB'(r_replays_left - 1'b1);
            end else begin
                n_replay_column = CB'(rcol0 + 1'b1);
            end
        end

        // Renormalize the accumulators against a new unit
        unique case (r_state)
            ST_RUN: begin
                if (i_unit_wr) begin
                    n_state    = ST_NORM;
                    n_norm_cnt = '0;
                    n_nh_part  = '0;
                    n_nh_q     = '0;
                    n_nv_part  = '0;
                    n_nv_q     = '0;
                end
            end
            ST_NORM: begin
                n_nh_part  = nh_part_step;
                n_nh_q     = nh_q_step;
                n_nv_part  = nv_part_step;
                n_nv_q     = nv_q_step;
                n_norm_cnt = NCW'(r_norm_cnt + 1'b1);
                if (r_norm_cnt == NCW'(ACC_W - 1)) begin
                    n_state = ST_RUN;
                    n_h_rem = nh_part_step;
                    n_v_rem = nv_part_step;
                    n_h_exc = (nh_q_step > ACC_W'(MAX_REPEAT)) ? QB'(MAX_REPEAT)
                                                                : nh_q_step[QB-1:0];
                    n_v_exc = (nv_q_step > ACC_W'(MAX_REPEAT)) ? QB'(MAX_REPEAT)
                                                                : nv_q_step[QB-1:0];
                end
            end
            default: n_state = ST_RUN;
        endcase

        // Command stage: load on accept, drain into the queue
        if (accept) begin
            n_f1_valid   = (pix_go && (copies != '0) && (h_cnt != '0)) || rep_go;
            n_f1_replay  = rep_go;
            n_f1_pixel   = i_pixel;
            n_f1_count   = h_cnt;
            n_f1_row_end = rep_go ? rep_last : pix_last;
        end else if (!i_full) begin
            n_f1_valid = 1'b0;
        end
    end

    // Hold state and command stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_RUN;
            r_column        <= '0;
            r_row_index     <= '0;
            r_row_copies    <= '0;
            r_replays_left  <= '0;
            r_replay_column <= '0;
            r_h_acc         <= '0;
            r_h_rem         <= '0;
            r_h_exc         <= '0;
            r_v_acc         <= '0;
            r_v_rem         <= '0;
            r_v_exc         <= '0;
            r_norm_cnt      <= '0;
            r_f1_valid      <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_column        <= n_column;
            r_row_index     <= n_row_index;
            r_row_copies    <= n_row_copies;
            r_replays_left  <= n_replays_left;
            r_replay_column <= n_replay_column;
            r_h_acc         <= n_h_acc;
            r_h_rem         <= n_h_rem;
            r_h_exc         <= n_h_exc;
            r_v_acc         <= n_v_acc;
            r_v_rem         <= n_v_rem;
            r_v_exc         <= n_v_exc;
            r_norm_cnt      <= n_norm_cnt;
            r_f1_valid      <= n_f1_valid;
        end
        r_nh_part    <= n_nh_part;
        r_nh_q       <= n_nh_q;
        r_nv_part    <= n_nv_part;
        r_nv_q       <= n_nv_q;
        r_f1_replay  <= n_f1_replay;
        r_f1_pixel   <= n_f1_pixel;
        r_f1_count   <= n_f1_count;
        r_f1_row_end <= n_f1_row_end;
    end

endmodule

/* hdl/nnps_back.sv */
// Copy engine: emits each queued pixel its count of times through an output register.
module nnps_back #(
    parameter int MAX_REPEAT = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_empty,
    input  logic [nnps_pkg::PIXEL_W+$clog2(MAX_REPEAT+1):0] i_entry,
    output logic                     o_pop,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [nnps_pkg::PIXEL_W-1:0] o_pixel,
    output logic                     o_last,
    output logic                     o_row_end
);

    import nnps_pkg::*;

    localparam int QB = $clog2(MAX_REPEAT + 1);

    logic [QB-1:0]      r_k;
    logic               r_valid;
    logic [PIXEL_W-1:0] r_pixel;
    logic               r_last;
    logic               r_row_end;
    logic [PIXEL_W-1:0] ent_pixel;
    logic [QB-1:0]      ent_cnt;
    logic               ent_flag;
    logic               free;
    logic               go;
    logic               last_copy;

    assign ent_pixel = i_entry[PIXEL_W-1:0];
    assign ent_cnt   = i_entry[PIXEL_W +: QB];
    assign ent_flag  = i_entry[PIXEL_W + QB];
    assign free      = !r_valid || i_ready;
    assign go        = free && !i_empty;
    assign last_copy = ((r_k + QB'(1)) == ent_cnt);
    assign o_pop     = go && last_copy;

    // Count copies of the head entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= '0;
            r_valid <= 1'b0;
        end else begin
            if (go) begin
                r_k <= last_copy ? '0 : QB'(r_k + 1'b1);
            end
            if (free) begin
                r_valid <= !i_empty;
            end
        end
    end

    // Load the output register when it is free
    always_ff @(posedge i_clk) begin
        if (go) begin
            r_pixel   <= ent_pixel;
            r_last    <= last_copy;
            r_row_end <= last_copy && ent_flag;
        end
    end

    assign o_valid   = r_valid;
    assign o_pixel   = r_pixel;
    assign o_last    = r_last;
    assign o_row_end = r_row_end;

endmodule

/* test/tb_nearest_neighbor_pixel_scaler_core.sv */
// Self-checking testbench for the nearest neighbor pixel scaler core.
`timescale 1ns / 100ps

module tb_nearest_neighbor_pixel_scaler_core;
    import nnps_pkg::*;

    localparam int unsigned SCALE_MAX_WIDTH  = 1024;
    localparam int unsigned SCALE_MAX_REPEAT = 16;
    localparam int unsigned TOTAL_ITEMS      = 470;
    localparam int unsigned WIDE_ITEMS       = 24;
    localparam int unsigned SETTLE_CYCLES    = 40;
    localparam int unsigned MAX_REPORTS      = 10;

    typedef struct packed {
        logic        kind;
        logic [31:0] pixel;
    } scaler_item_t;

    typedef struct packed {
        logic [31:0] pixel;
        logic        last;
        logic        row_end;
    } pixel_copy_t;

    // DUT ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [31:0] pixel
    logic        s_axis_tuser = 1'b0; // [0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [31:0] out_pixel
    logic        m_axis_tlast;
    logic        m_axis_tuser;        // [0] row_end

    // Stimulus and scoreboard
    scaler_item_t pending_items[$];
    pixel_copy_t  expected_copies[$];
    int unsigned  mismatch_count = 0;
    int unsigned  checked_copies = 0;
    int unsigned  item_total = 0;
    int unsigned  random_items = 0;
    int unsigned  reg_writes = 0;
    int unsigned  setting_count = 0;

    // Scaler state as predicted
    logic [31:0] held_pixel [SCALE_MAX_WIDTH];
    int unsigned held_count [SCALE_MAX_WIDTH];
    int unsigned run_acc = 0;
    int unsigned row_acc = 0;
    int unsigned col_pos = 0;
    int unsigned src_row = 0;
    int unsigned copies_this_row = 0;
    int unsigned replays_due = 0;
    int unsigned replay_pos = 0;

    // Register values as predicted
    int unsigned set_step   = RST_STEP;
    int unsigned set_unit   = RST_UNIT;
    int unsigned set_width  = RST_WIDTH;
    int unsigned set_height = RST_HEIGHT;

    // Handshake tracking
    bit src_fire = 1'b0;
    bit sink_fire = 1'b0;
    int src_wait = 0;
    int src_quiet = 0;
    int sink_wait = 0;
    int sink_quiet = 0;

    nearest_neighbor_pixel_scaler_core #(
        .MAX_WIDTH (SCALE_MAX_WIDTH),
        .MAX_REPEAT(SCALE_MAX_REPEAT)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    // Free-running clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Add the clamped step to an accumulator, keep the remainder, return the copy count
    function automatic int unsigned take_copies(inout int unsigned acc);
        int unsigned u, add, total, n;
        u = (set_unit == 0) ? 1 : set_unit;
        add = (set_step < SCALE_MAX_REPEAT * u) ? set_step : SCALE_MAX_REPEAT * u;
        total = acc + add;
        n = total / u;
        acc = total % u;
        return (n > SCALE_MAX_REPEAT) ? SCALE_MAX_REPEAT : n;
    endfunction

    // Queue n copies of one pixel, marking the last one
    function automatic void push_copies(logic [31:0] px, int unsigned n, bit row_last);
        pixel_copy_t c;
        int unsigned k;
        for (k = 0; k < n; k++) begin
            c.pixel = px;
            c.last = (k + 1 == n);
            c.row_end = (k + 1 == n) && row_last;
            expected_copies.push_back(c);
        end
    endfunction

    // Predict one item and queue it for the driver; return 1 unless the block ignores it
    function automatic bit queue_item(logic kind, logic [31:0] px);
        scaler_item_t it;
        int unsigned w, h, hc, c;
        bit row_last;
        bit took;
        w = (set_width == 0) ? 1 :
            (set_width > SCALE_MAX_WIDTH) ? SCALE_MAX_WIDTH : set_width;
        h = (set_height == 0) ? 1 : set_height;
        took = 1'b0;
        it.kind = kind;
        it.pixel = px;
        pending_items.push_back(it);
        item_total++;
        if (kind == KIND_PIXEL) begin
            if (replays_due == 0) begin
                took = 1'b1;
                if (col_pos >= w) col_pos = 0;
                // Row start: take the vertical count, restart the horizontal phase
                if (col_pos == 0) begin
                    copies_this_row = take_copies(row_acc);
                    run_acc = 0;
                end
                hc = take_copies(run_acc);
                held_pixel[col_pos] = px;
                held_count[col_pos] = hc;
                row_last = (col_pos + 1 >= w);
                if (copies_this_row != 0) push_copies(px, hc, row_last);
                if (row_last) begin
                    col_pos = 0;
                    if (copies_this_row > 1) begin
                        replays_due = copies_this_row - 1;
                        replay_pos = 0;
                    end
                    src_row = (src_row + 1) & 32'hFFFF;
                    if (src_row >= h) begin
                        src_row = 0;
                        row_acc = 0;
                    end
                end else begin
                    col_pos++;
                end
            end
        end else if (replays_due != 0) begin
            // Replay the next stored column of the current row
            took = 1'b1;
            if (replay_pos >= w) replay_pos = 0;
            c = replay_pos;
            row_last = (c + 1 >= w);
            push_copies(held_pixel[c], held_count[c], row_last);
            if (row_last) begin
                replay_pos = 0;
                replays_due--;
            end else begin
                replay_pos++;
            end
        end
        return took;
    endfunction

    // Play back all pending copies of the last row
    function automatic void finish_replays();
        while (replays_due != 0) void'(queue_item(KIND_REPLAY, $urandom));
    endfunction

    // Wait until every item is taken and every copy has arrived, then let the block settle
    task automatic drain_block();
        while (pending_items.size() != 0 || s_axis_tvalid || expected_copies.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register through the configuration channel
    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_STEP:   set_step = data;
            CFG_UNIT:   set_unit = data;
            CFG_WIDTH:  set_width = data[SWIDTH_W-1:0];
            CFG_HEIGHT: set_height = data;
            default:    ;
        endcase
        reg_writes++;
    endtask

    // Draw an idle count, with occasional stretches of back-to-back traffic
    function automatic int draw_gap(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            quiet_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    // Source driver: present queued items, hold each until taken
    always @(negedge i_clk) begin
        scaler_item_t it;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!(s_axis_tvalid && !src_fire)) begin
            if (src_wait > 0) begin
                s_axis_tvalid <= 1'b0;
                src_wait--;
            end else if (pending_items.size() != 0) begin
                it = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= it.pixel;
                s_axis_tuser <= it.kind;
                src_wait = draw_gap(src_quiet);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Sink: stall a random number of cycles after each copy
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (sink_fire) sink_wait = draw_gap(sink_quiet);
            if (sink_wait > 0) begin
                m_axis_tready <= 1'b0;
                sink_wait--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Monitor: track handshakes and check each copy against the oldest expectation
    always @(posedge i_clk) begin
        pixel_copy_t want;
        if (!i_rst_n) begin
            src_fire <= 1'b0;
            sink_fire <= 1'b0;
        end else begin
            src_fire <= s_axis_tvalid && s_axis_tready;
            sink_fire <= m_axis_tvalid && m_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                checked_copies++;
                if (expected_copies.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: unexpected copy pixel=%h last=%b row_end=%b",
                                 $realtime, m_axis_tdata, m_axis_tlast, m_axis_tuser);
                end else begin
                    want = expected_copies.pop_front();
                    if (m_axis_tdata !== want.pixel || m_axis_tlast !== want.last ||
                        m_axis_tuser !== want.row_end) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display({"%0t: copy mismatch exp pixel=%h last=%b row_end=%b,",
                                      " got pixel=%h last=%b row_end=%b"},
                                     $realtime, want.pixel, want.last, want.row_end,
                                     m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    end
                end
            end
        end
    end

    // Watchdog
    initial begin
        #30_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Stimulus sequence
    initial begin
        int unsigned k, phase_len, phase_count, u, lo, hi, pick;
        bit first_phase;
        logic kind;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: stray replay, then extreme pixel values
        void'(queue_item(KIND_REPLAY, 32'hFFFF_FFFF));
        void'(queue_item(KIND_PIXEL, 32'h0000_0000));
        void'(queue_item(KIND_PIXEL, 32'hFFFF_FFFF));
        void'(queue_item(KIND_PIXEL, 32'h5A5A_A5A5));
        drain_block();

        // Triple magnification on a two-pixel row; pixel while replays pend is dropped
        write_reg(CFG_WIDTH, 16'd2);
        write_reg(CFG_STEP, 16'd300);
        write_reg(CFG_UNIT, 16'd100);
        write_reg(CFG_HEIGHT, 16'd2);
        setting_count++;
        void'(queue_item(KIND_PIXEL, 32'h1234_5678));
        void'(queue_item(KIND_PIXEL, 32'h8765_4321));
        void'(queue_item(KIND_PIXEL, 32'hDEAD_BEEF));
        finish_replays();
        void'(queue_item(KIND_REPLAY, 32'h0));
        drain_block();

        // Zero unit and zero width: counts clamp at the maximum repeat
        write_reg(CFG_WIDTH, 16'd0);
        write_reg(CFG_STEP, 16'hFFFF);
        write_reg(CFG_UNIT, 16'd0);
        setting_count++;
        void'(queue_item(KIND_PIXEL, 32'hC3C3_3C3C));
        finish_replays();
        drain_block();

        // Zero height drops every row; then zero counts on columns and rows
        write_reg(CFG_STEP, 16'd1);
        write_reg(CFG_UNIT, 16'd2);
        write_reg(CFG_WIDTH, 16'd3);
        write_reg(CFG_HEIGHT, 16'd0);
        setting_count++;
        for (k = 0; k < 3; k++) void'(queue_item(KIND_PIXEL, $urandom));
        drain_block();
        write_reg(CFG_HEIGHT, 16'hFFFF);
        setting_count++;
        for (k = 0; k < 6; k++) void'(queue_item(KIND_PIXEL, $urandom));
        finish_replays();
        drain_block();

        // Width above the limit: the start of a wide row carries no row end
        write_reg(CFG_WIDTH, 16'd2047);
        write_reg(CFG_STEP, 16'd7);
        write_reg(CFG_UNIT, 16'd7);
        setting_count++;
        for (k = 0; k < WIDE_ITEMS; k++) void'(queue_item(KIND_PIXEL, $urandom));
        drain_block();

        // Random settings, mostly well-formed rows with some wrong-kind noise
        first_phase = 1'b1;
        while (item_total < TOTAL_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (first_phase || $urandom_range(0, 3) != 0)
                write_reg(CFG_UNIT, (pick == 0) ? 16'd1 : (pick == 1) ? 16'hFFFF :
                                    (pick == 2) ? 16'd0 : 16'($urandom_range(2, 400)));
            u = (set_unit == 0) ? 1 : set_unit;
            lo = (u / 4 > 0) ? u / 4 : 1;
            hi = (u * 4 < 65535) ? u * 4 : 65535;
            pick = $urandom_range(0, 9);
            if (first_phase || $urandom_range(0, 3) != 0)
                write_reg(CFG_STEP, (pick == 0) ? 16'd1 : (pick == 1) ? 16'hFFFF :
                                    (pick == 2) ? 16'($urandom_range(1, 65535)) :
                                    16'($urandom_range(lo, hi)));
            // Keep the width while replays pend so they read stored columns only
            pick = $urandom_range(0, 9);
            if (replays_due == 0 && (first_phase || $urandom_range(0, 3) != 0))
                write_reg(CFG_WIDTH, (pick == 0) ? 16'd0 :
                                     (pick == 1) ? 16'($urandom_range(1025, 2047)) :
                                     (pick == 2) ? 16'($urandom_range(13, 64)) :
                                     16'($urandom_range(1, 12)));
            pick = $urandom_range(0, 9);
            if (first_phase || $urandom_range(0, 3) != 0)
                write_reg(CFG_HEIGHT, (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
                                      16'($urandom_range(1, 6)));
            first_phase = 1'b0;
            setting_count++;

            phase_len = $urandom_range(20, 60);
            if (phase_len > TOTAL_ITEMS - item_total) phase_len = TOTAL_ITEMS - item_total;
            phase_count = 0;
            while (phase_count < phase_len) begin
                kind = (replays_due != 0) ? KIND_REPLAY : KIND_PIXEL;
                if ($urandom_range(0, 9) == 0) kind = ~kind;
                void'(queue_item(kind, $urandom));
                phase_count++;
            end
            random_items += phase_count;
            drain_block();
        end

        drain_block();
        $display("Sent %0d items (%0d random) over %0d settings with %0d register writes;",
                 item_total, random_items, setting_count, reg_writes);
        $display("checked %0d pixel copies, %0d mismatches.", checked_copies, mismatch_count);
        if (mismatch_count == 0 && expected_copies.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
